/* sv/spq_pkg.sv */
// Package for the sorted priority queue: request codes, payload structs and
// the per-cell control struct. No dependencies.

package spq_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned OPCODE_W      = 2;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned POSITION_W    = 4;
  localparam int unsigned COUNT_OUT_W   = 5;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_INSERT  = 2'd2
  } spq_op_e;

  typedef struct packed {
    logic [OPCODE_W-1:0]          opcode;
    logic signed [VALUE_W-1:0]    item_value;
    logic [POSITION_W-1:0]        position;
  } spq_req_t;

  typedef struct packed {
    logic                         accepted;
    logic [COUNT_OUT_W-1:0]       item_count;
    logic signed [VALUE_W-1:0]    out_value;
  } spq_rsp_t;

  // Broadcast to every cell; at most one bit is set, and only for a carried-out request.
  typedef struct packed {
    logic enq;
    logic deq;
    logic ins;
  } spq_ctrl_t;

endpackage

/* sv/spq_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on spq_pkg for the payload structs.

interface spq_req_if
  import spq_pkg::*;
;
  logic     valid;
  logic     ready;
  spq_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spq_rsp_if
  import spq_pkg::*;
;
  logic     valid;
  logic     ready;
  spq_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/spq_cell.sv */
// One rank of the queue: holds a value, compares it with the incoming value and
// loads, keeps or takes a neighbor's value. Depends on spq_pkg.

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned IDX_W = 5
) (
  input  logic                      clk_i,
  input  spq_ctrl_t                 ctrl_i,
  input  logic [IDX_W-1:0]          count_i,
  input  logic [IDX_W-1:0]          pos_i,
  input  logic signed [VALUE_W-1:0] new_value_i,
  input  logic signed [VALUE_W-1:0] left_value_i,
  input  logic signed [VALUE_W-1:0] right_value_i,
  input  logic                      found_i,
  output logic                      found_o,
  output logic signed [VALUE_W-1:0] value_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic signed [VALUE_W-1:0] value_q, value_d;
  logic                      occupied;
  logic                      hit;

  assign occupied = MyIdx < count_i;
  assign hit      = occupied && (new_value_i < value_q);
  assign found_o  = found_i | hit;
  assign value_o  = value_q;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.enq) begin
      if (found_i && (MyIdx <= count_i)) begin
        value_d = left_value_i;
      end else if (!found_i && (hit || (MyIdx == count_i))) begin
        value_d = new_value_i;
      end
    end else if (ctrl_i.ins) begin
      if (MyIdx == pos_i) begin
        value_d = new_value_i;
      end else if ((MyIdx > pos_i) && (MyIdx <= count_i)) begin
        value_d = left_value_i;
      end
    end else if (ctrl_i.deq) begin
      if (occupied) begin
        value_d = right_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* sv/sorted_priority_queue.sv */
// Top level of the sorted priority queue: request decode, occupancy count,
// the row of spq_cell ranks and the response register. Depends on spq_pkg, spq_if.
//
//   channel  direction  payload
//   req_i    in         opcode, item_value, position
//   rsp_o    out        accepted, item_count, out_value
//
// Each request is carried out by the whole row of cells at the edge that accepts
// it, and its response is registered for the next cycle. A new request is
// accepted whenever the response register is empty or is being drained, so
// requests can follow each other every cycle. The longest path is the first-match
// chain that runs from rank zero through every cell.
// Reset clears the count and the response valid; stored values are not cleared.

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_req_if.sink    req_i,
  spq_rsp_if.source  rsp_o
);

  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW   = (CountW > POSITION_W) ? CountW : POSITION_W;
  localparam int unsigned ExtW   = (CountW > COUNT_OUT_W) ? CountW : COUNT_OUT_W;

  logic [CountW-1:0]         count_q, count_d;
  logic                      rsp_valid_q;
  spq_rsp_t                  rsp_q, rsp_d;
  logic                      req_fire;
  logic                      full, empty;
  logic [IdxW-1:0]           count_idx;
  logic [IdxW-1:0]           pos_idx;
  logic                      is_enq, is_deq, is_ins;
  logic                      ok;
  spq_ctrl_t                 ctrl;
  logic [ExtW-1:0]           count_ext;

  logic                      found [QUEUE_DEPTH+1];
  logic signed [VALUE_W-1:0] vals  [QUEUE_DEPTH];

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  assign full      = count_q == CountW'(QUEUE_DEPTH);
  assign empty     = count_q == '0;
  assign count_idx = IdxW'(count_q);
  assign pos_idx   = IdxW'(req_i.data.position);

  assign is_enq = req_i.data.opcode == OP_ENQUEUE;
  assign is_deq = req_i.data.opcode == OP_DEQUEUE;
  assign is_ins = req_i.data.opcode == OP_INSERT;

  always_comb begin
    ok = 1'b0;
    if (is_enq) begin
      ok = !full;
    end else if (is_deq) begin
      ok = !empty;
    end else if (is_ins) begin
      ok = !full && (pos_idx <= count_idx);
    end
  end

  assign ctrl.enq = req_fire && ok && is_enq;
  assign ctrl.deq = req_fire && ok && is_deq;
  assign ctrl.ins = req_fire && ok && is_ins;

  always_comb begin
    count_d = count_q;
    if (ctrl.enq || ctrl.ins) begin
      count_d = count_q + CountW'(1);
    end else if (ctrl.deq) begin
      count_d = count_q - CountW'(1);
    end
  end

  assign count_ext = ExtW'(count_d);

  always_comb begin
    rsp_d.accepted   = ok;
    rsp_d.item_count = count_ext[COUNT_OUT_W-1:0];
    rsp_d.out_value  = (ok && is_deq) ? vals[0] : '0;
  end

  assign found[0] = 1'b0;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic signed [VALUE_W-1:0] left_value;
    logic signed [VALUE_W-1:0] right_value;

    if (g == 0) begin : g_head
      assign left_value = req_i.data.item_value;
    end else begin : g_body
      assign left_value = vals[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_value = vals[g];
    end else begin : g_mid
      assign right_value = vals[g+1];
    end

    spq_cell #(
      .INDEX (g),
      .IDX_W (IdxW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .count_i       (count_idx),
      .pos_i         (pos_idx),
      .new_value_i   (req_i.data.item_value),
      .left_value_i  (left_value),
      .right_value_i (right_value),
      .found_i       (found[g]),
      .found_o       (found[g+1]),
      .value_o       (vals[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QUEUE_DEPTH))
    else $error("occupancy exceeds queue depth");

  a_deq_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && is_deq && !empty) |=> (count_q == $past(count_q) - CountW'(1)))
    else $error("dequeue did not lower the occupancy by one");

  a_reject_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && !ok) |=> $stable(count_q))
    else $error("rejected request changed the occupancy");

  a_rsp_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> (rsp_q.item_count == COUNT_OUT_W'(count_q)))
    else $error("response count does not match the occupancy");
`endif

endmodule

/* tb/sv/tb_sorted_priority_queue.sv */
// Self-checking testbench for sorted_priority_queue: random and directed requests
// against a cycle-free model of the sorted store, with random stalls on both channels.
// Depends on spq_pkg, spq_if and the sorted_priority_queue RTL.

module tb_sorted_priority_queue;
  import spq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = DEFAULT_DEPTH;
  localparam int unsigned RANDOM_REQS = 450;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  spq_req_if req_if ();
  spq_rsp_if rsp_if ();

  sorted_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #4 clk_i = ~clk_i;

  spq_req_t pending_reqs[$];
  spq_rsp_t expected_rsps[$];

  logic signed [VALUE_W-1:0] store_values[DEPTH];
  int unsigned store_count;
  int unsigned gen_count;

  int unsigned errors;
  int unsigned sent_reqs;
  int unsigned checked_rsps;
  int unsigned rejected_reqs;
  int unsigned full_hits;
  int unsigned empty_hits;
  int unsigned cycles;

  logic     req_fire;
  spq_req_t req_seen;
  logic     rsp_fire;
  spq_rsp_t rsp_seen;
  logic     calm;

  assign calm = (sent_reqs >= 200) && (sent_reqs < 320);

  // Updates the sorted store for one request and queues the response.
  task automatic apply_request(input spq_req_t r);
    spq_rsp_t                  rsp;
    logic signed [VALUE_W-1:0] v;
    int unsigned               where;
    int unsigned               i;
    logic                      ok;
    logic                      place;
    v     = r.item_value;
    ok    = 1'b0;
    place = 1'b0;
    where = store_count;
    rsp   = '0;
    case (r.opcode)
      OP_ENQUEUE: begin
        if (store_count < DEPTH) begin
          for (i = 0; i < store_count; i++) begin
            if (v < store_values[i]) begin
              where = i;
              break;
            end
          end
          place = 1'b1;
        end else begin
          full_hits++;
        end
      end
      OP_DEQUEUE: begin
        if (store_count > 0) begin
          rsp.out_value = store_values[0];
          for (i = 1; i < store_count; i++) store_values[i-1] = store_values[i];
          store_count--;
          ok = 1'b1;
        end else begin
          empty_hits++;
        end
      end
      OP_INSERT: begin
        if (store_count < DEPTH && r.position <= store_count) begin
          where = int'(r.position);
          place = 1'b1;
        end else if (store_count == DEPTH) begin
          full_hits++;
        end
      end
      default: ;
    endcase
    if (place) begin
      for (i = store_count; i > where; i--) store_values[i] = store_values[i-1];
      store_values[where] = v;
      store_count++;
      ok = 1'b1;
    end
    rsp.accepted   = ok;
    rsp.item_count = store_count[COUNT_OUT_W-1:0];
    if (!rsp.accepted) rejected_reqs++;
    expected_rsps.push_back(rsp);
  endtask

  task automatic push_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] v,
                              input logic [POSITION_W-1:0] pos);
    spq_req_t r;
    r.opcode     = op;
    r.item_value = v;
    r.position   = pos;
    pending_reqs.push_back(r);
    case (op)
      OP_ENQUEUE: if (gen_count < DEPTH) gen_count++;
      OP_DEQUEUE: if (gen_count > 0) gen_count--;
      OP_INSERT:  if (gen_count < DEPTH && pos <= gen_count) gen_count++;
      default: ;
    endcase
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          2:       v = '0;
          default: v = '1;
        endcase
      end
      1, 2, 3, 4: v = $urandom_range(0, 20) - 10;
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(negedge clk_i) begin
    req_fire <= req_if.valid && req_if.ready;
    req_seen <= req_if.data;
    rsp_fire <= rsp_if.valid && rsp_if.ready;
    rsp_seen <= rsp_if.data;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_fire) begin
        apply_request(req_seen);
        sent_reqs++;
      end
      if (!req_if.valid || req_fire) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    spq_rsp_t exp_rsp;
    if (rst_ni) begin
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 30);
      if (rsp_fire) begin
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding");
          errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          checked_rsps++;
          if (rsp_seen.accepted !== exp_rsp.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_rsp.accepted, rsp_seen.accepted);
            errors++;
          end
          if (rsp_seen.item_count !== exp_rsp.item_count) begin
            $error("item_count: expected %0d, got %0d", exp_rsp.item_count,
                   rsp_seen.item_count);
            errors++;
          end
          if (rsp_seen.out_value !== exp_rsp.out_value) begin
            $error("out_value: expected %0d, got %0d", exp_rsp.out_value,
                   rsp_seen.out_value);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned burst;
    int unsigned r;
    logic        grow;
    logic [OPCODE_W-1:0]   op;
    logic [POSITION_W-1:0] pos;

    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    rsp_if.ready   = 1'b0;
    req_fire       = 1'b0;
    rsp_fire       = 1'b0;
    req_seen       = '0;
    rsp_seen       = '0;
    store_count    = 0;
    gen_count      = 0;
    errors         = 0;
    sent_reqs      = 0;
    checked_rsps   = 0;
    rejected_reqs  = 0;
    full_hits      = 0;
    empty_hits     = 0;
    cycles         = 0;
    foreach (store_values[i]) store_values[i] = '0;

    push_request(OP_DEQUEUE, '0, '0);
    push_request(OP_UNUSED, '1, 4'd15);
    push_request(OP_INSERT, 32'd7, 4'd1);
    push_request(OP_INSERT, 32'h7fff_ffff, 4'd0);
    push_request(OP_ENQUEUE, 32'h8000_0000, 4'd0);
    push_request(OP_ENQUEUE, 32'h7fff_ffff, 4'd15);
    push_request(OP_INSERT, -32'sd5, 4'd3);
    push_request(OP_INSERT, 32'd100, 4'd1);
    push_request(OP_ENQUEUE, 32'd50, 4'd0);
    while (gen_count < DEPTH) push_request(OP_ENQUEUE, pick_value(), 4'($urandom));
    push_request(OP_ENQUEUE, 32'd1, 4'd0);
    push_request(OP_INSERT, 32'd2, 4'd15);
    push_request(OP_DEQUEUE, '0, '0);
    push_request(OP_DEQUEUE, '0, '0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    n = 0;
    while (n < RANDOM_REQS) begin
      grow  = $urandom_range(0, 1);
      burst = $urandom_range(10, 30);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (grow) begin
          op = (r < 55) ? OP_ENQUEUE : (r < 80) ? OP_INSERT : (r < 95) ? OP_DEQUEUE : OP_UNUSED;
        end else begin
          op = (r < 60) ? OP_DEQUEUE : (r < 75) ? OP_ENQUEUE : (r < 90) ? OP_INSERT : OP_UNUSED;
        end
        if ($urandom_range(0, 99) < 80) begin
          pos = (gen_count >= 15) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, gen_count));
        end else begin
          pos = 4'($urandom);
        end
        push_request(op, pick_value(), pos);
        n++;
        if (n == RANDOM_REQS / 2) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (10) @(negedge clk_i);

    $display("%0d requests checked, %0d rejected (%0d on a full queue, %0d on an empty one)",
             checked_rsps, rejected_reqs, full_hits, empty_hits);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
